/* hdl/mdu_pkg.sv */
`timescale 1ns / 1ps

package mdu_pkg;

   // Byte offsets of the two register blocks inside the bus window.
   localparam logic [7:0] WRITE_BLOCK_BASE  = 8'd2;
   localparam logic [7:0] RESULT_BLOCK_BASE = 8'd20;

   localparam logic [7:0] WRITE_BLOCK_SIZE  = 8'd5;
   localparam logic [7:0] RESULT_BLOCK_SIZE = 8'd4;

   localparam logic [7:0]  BYTE_ONES = 8'hff;
   localparam logic [15:0] WORD_ONES = 16'hffff;

   // Access kinds carried on the request tuser bit.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Registers of the write block, by position from its base.
   typedef enum logic [2:0] {
      WREG_MULT_A,
      WREG_MULT_B,
      WREG_DIVIDEND_LO,
      WREG_DIVIDEND_HI,
      WREG_DIVISOR
   } wreg_type;

   // Bytes of the result block, by position from its base.
   typedef enum logic [1:0] {
      RREG_QUOT_LO,
      RREG_QUOT_HI,
      RREG_PROD_REM_LO,
      RREG_PROD_REM_HI
   } rreg_type;

endpackage

/* hdl/mmio_multiply_divide_unit.sv */
`timescale 1ns / 1ps

// Byte-wide memory-mapped multiply and divide unit.
// Each item on the req channel is one bus access: tuser carries the access kind
// (0 read, 1 write) and tdata carries the register offset and the write byte.
// Every accepted item yields exactly one item on the rsp channel holding the
// byte read back, or zero for a write.
// Writing multiplicand B starts an 8x8 shift-and-add multiply that retires one
// multiplier bit per cycle; writing the divisor starts a 16/8 restoring divide
// that retires one quotient bit per cycle. A zero divisor is settled at once.
// Every response is registered and valid in the cycle after its access is accepted.
// A read or a plain write leaves the block idle; a write to B keeps req_tready
// low while the multiply loop runs, and a write to a nonzero divisor while the
// divide loop runs.
// The response sits in an output register, so the next item can be accepted in
// the same cycle that the previous response is taken; while rsp_tready is low
// and a response waits, req_tready stays low and nothing is lost.
// Synchronous reset sets every register of the two blocks to all ones and empties the output.
module mmio_multiply_divide_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] reg_offset, [15:8] write_data
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] read_data
);
   import mdu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type   state_ff;
   logic [3:0]  cnt_ff;

   logic [7:0]  mult_a_ff;
   logic [7:0]  mult_b_ff;
   logic [15:0] dividend_ff;
   logic [7:0]  divisor_ff;
   logic [15:0] quotient_ff;
   logic [15:0] prod_rem_ff;
   logic [7:0]  rem_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;

   logic        req_acc;
   logic        is_write;
   logic [7:0]  offset;
   logic [7:0]  wdata;
   logic [7:0]  wsel;
   logic [7:0]  rsel;
   logic        hit_write;
   logic        hit_result;
   wreg_type    wreg;
   rreg_type    rreg;
   logic [7:0]  rsp_data_in;

   logic [8:0]  mul_sum;
   logic [8:0]  div_shl;
   logic [8:0]  div_diff;
   logic        div_ge;
   logic [7:0]  rem_in;

   assign offset   = req_tdata[7:0];
   assign wdata    = req_tdata[15:8];
   assign is_write = (req_tuser[0] == OP_WRITE);

   // The block takes a new access only when no operation runs and the output
   // register is empty or being emptied in this cycle.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Address decode; the write block wins where the two blocks overlap.
   assign wsel       = offset - WRITE_BLOCK_BASE;
   assign rsel       = offset - RESULT_BLOCK_BASE;
   assign hit_write  = (offset >= WRITE_BLOCK_BASE) && (wsel < WRITE_BLOCK_SIZE);
   assign hit_result = !hit_write && (offset >= RESULT_BLOCK_BASE) &&
                       (rsel < RESULT_BLOCK_SIZE);
   assign wreg       = wreg_type'(wsel[2:0]);
   assign rreg       = rreg_type'(rsel[1:0]);

   always_comb begin
      rsp_data_in = 8'h00;
      if (!is_write && hit_write) begin
         case (wreg)
            WREG_MULT_A:      rsp_data_in = mult_a_ff;
            WREG_MULT_B:      rsp_data_in = mult_b_ff;
            WREG_DIVIDEND_LO: rsp_data_in = dividend_ff[7:0];
            WREG_DIVIDEND_HI: rsp_data_in = dividend_ff[15:8];
            WREG_DIVISOR:     rsp_data_in = divisor_ff;
            default:          rsp_data_in = 8'h00;
         endcase
      end else if (!is_write && hit_result) begin
         case (rreg)
            RREG_QUOT_LO:     rsp_data_in = quotient_ff[7:0];
            RREG_QUOT_HI:     rsp_data_in = quotient_ff[15:8];
            RREG_PROD_REM_LO: rsp_data_in = prod_rem_ff[7:0];
            RREG_PROD_REM_HI: rsp_data_in = prod_rem_ff[15:8];
            default:          rsp_data_in = 8'h00;
         endcase
      end
   end

   // Multiply step: the multiplier sits in the low byte of prod_rem_ff and is
   // shifted out while partial sums enter from the top.
   assign mul_sum = {1'b0, prod_rem_ff[15:8]} +
                    (prod_rem_ff[0] ? {1'b0, mult_a_ff} : 9'd0);

   // Restoring divide step: bring down the next dividend bit and subtract the
   // divisor when it fits.
   assign div_shl  = {rem_ff, quotient_ff[15]};
   assign div_diff = div_shl - {1'b0, divisor_ff};
   assign div_ge   = (div_shl >= {1'b0, divisor_ff});
   assign rem_in   = div_ge ? div_diff[7:0] : div_shl[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         mult_a_ff    <= BYTE_ONES;
         mult_b_ff    <= BYTE_ONES;
         dividend_ff  <= WORD_ONES;
         divisor_ff   <= BYTE_ONES;
         quotient_ff  <= WORD_ONES;
         prod_rem_ff  <= WORD_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc && is_write && hit_write) begin
                  case (wreg)
                     WREG_MULT_A: begin
                        mult_a_ff <= wdata;
                     end
                     WREG_MULT_B: begin
                        mult_b_ff   <= wdata;
                        prod_rem_ff <= {8'h00, wdata};
                        cnt_ff      <= 4'd0;
                        state_ff    <= ST_MUL;
                     end
                     WREG_DIVIDEND_LO: begin
                        dividend_ff[7:0] <= wdata;
                     end
                     WREG_DIVIDEND_HI: begin
                        dividend_ff[15:8] <= wdata;
                     end
                     WREG_DIVISOR: begin
                        divisor_ff <= wdata;
                        if (wdata == 8'h00) begin
                           quotient_ff <= WORD_ONES;
                           prod_rem_ff <= dividend_ff;
                        end else begin
                           quotient_ff <= dividend_ff;
                           rem_ff      <= 8'h00;
                           cnt_ff      <= 4'd0;
                           state_ff    <= ST_DIV;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_MUL: begin
               prod_rem_ff <= {mul_sum, prod_rem_ff[7:1]};
               if (cnt_ff == 4'd7) begin
                  cnt_ff   <= 4'd0;
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_DIV: begin
               rem_ff      <= rem_in;
               quotient_ff <= {quotient_ff[14:0], div_ge};
               if (cnt_ff == 4'd15) begin
                  prod_rem_ff <= {8'h00, rem_in};
                  cnt_ff      <= 4'd0;
                  state_ff    <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               cnt_ff   <= 4'd0;
            end
         endcase
      end
   end

   // The step counter only runs while an operation is in flight.
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == 4'd0))
      else $error("step counter nonzero while idle");

   // A divide only iterates with a nonzero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (divisor_ff != 8'h00))
      else $error("divide running with zero divisor");

   // A write to multiplicand B starts the multiply.
   a_mul_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && is_write && hit_write && (wreg == WREG_MULT_B))
      |=> (state_ff == ST_MUL))
      else $error("multiply did not start");

   // Every write returns a zero byte.
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (req_acc && is_write) |=> (rsp_tvalid && (rsp_tdata == 8'h00)))
      else $error("write response is not zero");

   // Accepting never overwrites a response that is still waiting.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_acc)
      else $error("response overwritten");

endmodule

/* tb/tb_mmio_multiply_divide_unit.sv */
`timescale 1ns / 1ps

// Self-checking bench for the memory-mapped multiply and divide unit.
// Every bus access goes in on the req stream and gives exactly one byte back on
// the rsp stream. A shadow copy of the register file, kept in this module,
// predicts that byte at the moment the access is accepted. A checker takes
// every response and compares it against the oldest prediction still waiting.
module tb_mmio_multiply_divide_unit;
   import mdu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // [7:0] reg_offset, [15:8] write_data
   logic [0:0]  req_tuser  = OP_READ;    // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;               // [7:0] read_data

   // Shadow register file. It follows every accepted access in order.
   logic [7:0]  shadow_mult_a;
   logic [7:0]  shadow_mult_b;
   logic [15:0] shadow_dividend;
   logic [7:0]  shadow_divisor;
   logic [15:0] shadow_quotient;
   logic [15:0] shadow_prod_rem;

   // Response bytes that the block still owes, oldest first.
   logic [7:0]  pending_read_bytes[$];
   logic [7:0]  oldest_byte;

   int items_sent        = 0;
   int responses_checked = 0;
   int products_formed   = 0;
   int quotients_formed  = 0;
   int zero_divides      = 0;
   int mismatch_count    = 0;
   int quiet_cycles      = 0;
   int rsp_stall_left    = 0;
   bit no_idling         = 1'b0;

   always #5 clock = ~clock;

   mmio_multiply_divide_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [7:0] wreg_offset(input wreg_type r);
      return WRITE_BLOCK_BASE + 8'(r);
   endfunction

   function automatic logic [7:0] rreg_offset(input rreg_type r);
      return RESULT_BLOCK_BASE + 8'(r);
   endfunction

   // A random byte that lands on all zeros or all ones fairly often.
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return BYTE_ONES;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Divisors lean toward zero, one and small values, where quotients are wide.
   function automatic logic [7:0] rand_divisor();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'($urandom_range(1, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input logic [7:0] want,
                                         input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
   endfunction

   function automatic void reset_shadow();
      shadow_mult_a   = BYTE_ONES;
      shadow_mult_b   = BYTE_ONES;
      shadow_dividend = WORD_ONES;
      shadow_divisor  = BYTE_ONES;
      shadow_quotient = WORD_ONES;
      shadow_prod_rem = WORD_ONES;
   endfunction

   // Applies one access to the shadow registers and returns the byte that the
   // block must answer with. Where the two blocks overlap, the write block wins.
   task automatic predict_access(input logic op, input logic [7:0] offset,
                                 input logic [7:0] wbyte, output logic [7:0] rbyte);
      logic [7:0] w_idx;
      logic [7:0] r_idx;
      logic       in_write;
      logic       in_result;
      w_idx     = offset - WRITE_BLOCK_BASE;
      r_idx     = offset - RESULT_BLOCK_BASE;
      in_write  = (offset >= WRITE_BLOCK_BASE) && (w_idx < WRITE_BLOCK_SIZE);
      in_result = (offset >= RESULT_BLOCK_BASE) && (r_idx < RESULT_BLOCK_SIZE);
      rbyte     = 8'h00;
      if (op == OP_WRITE) begin
         // Writes to result bytes and to unmapped offsets change nothing.
         if (in_write) begin
            case (wreg_type'(w_idx[2:0]))
               WREG_MULT_A: shadow_mult_a = wbyte;
               WREG_MULT_B: begin
                  shadow_mult_b   = wbyte;
                  shadow_prod_rem = 16'(shadow_mult_a) * 16'(shadow_mult_b);
                  products_formed++;
               end
               WREG_DIVIDEND_LO: shadow_dividend[7:0]  = wbyte;
               WREG_DIVIDEND_HI: shadow_dividend[15:8] = wbyte;
               WREG_DIVISOR: begin
                  shadow_divisor = wbyte;
                  if (wbyte == 8'h00) begin
                     shadow_quotient = WORD_ONES;
                     shadow_prod_rem = shadow_dividend;
                     zero_divides++;
                  end else begin
                     shadow_quotient = shadow_dividend / 16'(wbyte);
                     shadow_prod_rem = shadow_dividend % 16'(wbyte);
                  end
                  quotients_formed++;
               end
               default: ;
            endcase
         end
      end else if (in_write) begin
         case (wreg_type'(w_idx[2:0]))
            WREG_MULT_A:      rbyte = shadow_mult_a;
            WREG_MULT_B:      rbyte = shadow_mult_b;
            WREG_DIVIDEND_LO: rbyte = shadow_dividend[7:0];
            WREG_DIVIDEND_HI: rbyte = shadow_dividend[15:8];
            default:          rbyte = shadow_divisor;
         endcase
      end else if (in_result) begin
         case (rreg_type'(r_idx[1:0]))
            RREG_QUOT_LO:     rbyte = shadow_quotient[7:0];
            RREG_QUOT_HI:     rbyte = shadow_quotient[15:8];
            RREG_PROD_REM_LO: rbyte = shadow_prod_rem[7:0];
            default:          rbyte = shadow_prod_rem[15:8];
         endcase
      end
   endtask

   // Presents one item and holds it until the block takes it. Called right
   // after a rising edge; tvalid stays high afterwards so that the next call
   // can follow back to back without lowering it.
   task automatic send_access(input logic op, input logic [7:0] offset,
                              input logic [7:0] wbyte);
      logic [7:0] rbyte;
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wbyte, offset};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_access(op, offset, wbyte, rbyte);
      pending_read_bytes.push_back(rbyte);
      items_sent++;
   endtask

   task automatic write_reg(input logic [7:0] offset, input logic [7:0] wbyte);
      send_access(OP_WRITE, offset, wbyte);
   endtask

   // The write byte of a read carries noise; the block must ignore it.
   task automatic read_reg(input logic [7:0] offset);
      send_access(OP_READ, offset, rand_byte());
   endtask

   task automatic test_reset_values();
      read_reg(wreg_offset(WREG_MULT_A));
      read_reg(wreg_offset(WREG_DIVISOR));
      read_reg(rreg_offset(RREG_QUOT_LO));
      read_reg(rreg_offset(RREG_PROD_REM_HI));
      read_reg(8'h00);
      read_reg(8'hff);
   endtask

   task automatic test_multiply();
      write_reg(wreg_offset(WREG_MULT_A), BYTE_ONES);
      write_reg(wreg_offset(WREG_MULT_B), BYTE_ONES);
      read_reg(rreg_offset(RREG_PROD_REM_LO));
      read_reg(rreg_offset(RREG_PROD_REM_HI));
      write_reg(wreg_offset(WREG_MULT_B), 8'h00);
      read_reg(rreg_offset(RREG_PROD_REM_LO));
   endtask

   // A zero divisor first, then the largest divisor on the same dividend.
   task automatic test_divide();
      write_reg(wreg_offset(WREG_DIVIDEND_LO), 8'h34);
      write_reg(wreg_offset(WREG_DIVIDEND_HI), 8'h12);
      write_reg(wreg_offset(WREG_DIVISOR), 8'h00);
      read_reg(rreg_offset(RREG_QUOT_HI));
      read_reg(rreg_offset(RREG_PROD_REM_LO));
      read_reg(rreg_offset(RREG_PROD_REM_HI));
      write_reg(wreg_offset(WREG_DIVISOR), BYTE_ONES);
      read_reg(rreg_offset(RREG_QUOT_LO));
   endtask

   task automatic test_unmapped_and_readonly();
      write_reg(rreg_offset(RREG_QUOT_LO), 8'h5a);
      read_reg(rreg_offset(RREG_QUOT_LO));
      write_reg(8'hff, 8'h00);
      read_reg(wreg_offset(WREG_DIVIDEND_LO));
   endtask

   // Mostly complete multiply and divide sequences with random operands, products
   // read back in either byte order, mixed with stray reads and accesses anywhere.
   task automatic run_random_traffic(input int n_items);
      int start_count;
      start_count = items_sent;
      while (items_sent - start_count < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               if ($urandom_range(0, 3) != 0)
                  write_reg(wreg_offset(WREG_MULT_A), rand_byte());
               write_reg(wreg_offset(WREG_MULT_B), rand_byte());
               if ($urandom_range(0, 1) == 0) begin
                  read_reg(rreg_offset(RREG_PROD_REM_LO));
                  read_reg(rreg_offset(RREG_PROD_REM_HI));
               end else begin
                  read_reg(rreg_offset(RREG_PROD_REM_HI));
                  read_reg(rreg_offset(RREG_PROD_REM_LO));
               end
            end
            3, 4, 5: begin
               if ($urandom_range(0, 1) == 0) begin
                  write_reg(wreg_offset(WREG_DIVIDEND_LO), rand_byte());
                  write_reg(wreg_offset(WREG_DIVIDEND_HI), rand_byte());
               end else begin
                  write_reg(wreg_offset(WREG_DIVIDEND_HI), rand_byte());
                  write_reg(wreg_offset(WREG_DIVIDEND_LO), rand_byte());
               end
               write_reg(wreg_offset(WREG_DIVISOR), rand_divisor());
               read_reg(rreg_offset(RREG_QUOT_LO));
               read_reg(rreg_offset(RREG_QUOT_HI));
               read_reg(rreg_offset(RREG_PROD_REM_LO));
               read_reg(rreg_offset(RREG_PROD_REM_HI));
            end
            6, 7: read_reg(8'($urandom_range(0, 31)));
            default: send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 rand_byte());
         endcase
      end
   endtask

   task automatic test_random_traffic();
      run_random_traffic(400);
   endtask

   // Closing stretch with the bench always ready, so items can run back to back.
   task automatic test_back_to_back();
      no_idling = 1'b1;
      run_random_traffic(100);
   endtask

   // The receiver stalls in random bursts, except in the closing stretch.
   always @(posedge clock) begin
      if (reset || no_idling) begin
         rsp_tready     <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall_left <= $urandom_range(0, 4);
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every response taken is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_read_bytes.size() == 0) begin
            note_mismatch("response with no access pending", 8'h00, rsp_tdata);
         end else begin
            oldest_byte = pending_read_bytes.pop_front();
            responses_checked++;
            if (rsp_tdata !== oldest_byte)
               note_mismatch("read_data", oldest_byte, rsp_tdata);
         end
      end
   end

   // The run is stuck if neither stream moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout with %0d responses outstanding", pending_read_bytes.size());
            $display("tb_mmio_multiply_divide_unit: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_multiply();
      test_divide();
      test_unmapped_and_readonly();
      test_random_traffic();
      test_back_to_back();

      req_tvalid <= 1'b0;
      while (pending_read_bytes.size() != 0) @(posedge clock);
      // Linger so that a stray extra response would still be caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d accesses sent, %0d responses checked, %0d mismatches", items_sent,
               responses_checked, mismatch_count);
      $display("%0d products and %0d quotients formed, %0d of them with a zero divisor",
               products_formed, quotients_formed, zero_divides);
      if (mismatch_count == 0)
         $display("tb_mmio_multiply_divide_unit: done, clean");
      else
         $display("tb_mmio_multiply_divide_unit: done, errors");
      $finish;
   end

endmodule
